// ===== design/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, codes and constants of the IR carrier sweep scheduler.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth  = 16;
  localparam int AccWidth      = 17;

  localparam logic [CfgIndexWidth-1:0] CFG_BURST_INTERVAL = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_BURST_LENGTH   = 1'd1;

  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_TOGGLE    = 2'd1;
  localparam logic [1:0] FUNC_NEXT_MODE = 2'd2;
  localparam logic [1:0] FUNC_RESET_HZ  = 2'd3;

  localparam logic [1:0] MODE_NARROW = 2'd0;
  localparam logic [1:0] MODE_WIDE   = 2'd1;
  localparam logic [1:0] MODE_FIXED  = 2'd2;

  localparam logic [15:0] INTERVAL_RESET = 16'd120;
  localparam logic [15:0] LENGTH_RESET   = 16'd46;
  localparam logic [15:0] FIXED_HZ       = 16'd38000;
  localparam logic [15:0] NARROW_MIN_HZ  = 16'd36000;
  localparam logic [15:0] NARROW_MAX_HZ  = 16'd40000;
  localparam logic [15:0] WIDE_MIN_HZ    = 16'd30000;
  localparam logic [15:0] WIDE_MAX_HZ    = 16'd60000;
  localparam logic [15:0] NARROW_STEP_HZ = 16'd1000;
  localparam logic [15:0] WIDE_STEP_HZ   = 16'd2000;
  localparam logic [AccWidth-1:0] ACC_MAX = {AccWidth{1'b1}};

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] dt_ms;
    logic        emitter_ok;
  } in_item_t;

  typedef struct packed {
    logic        burst_fire;
    logic [15:0] burst_carrier_hz;
    logic [15:0] burst_ms;
    logic        stop_emitter;
    logic        is_running;
    logic [1:0]  sweep_mode;
    logic [15:0] current_carrier_hz;
    logic [31:0] burst_total;
  } out_item_t;

  typedef struct packed {
    logic [15:0] carrier;
    logic        going_up;
  } sweep_t;

  typedef struct packed {
    logic                running;
    logic [AccWidth-1:0] elapsed_acc;
    sweep_t              sweep;
    logic [1:0]          mode;
    logic [31:0]         burst_counter;
  } state_t;

endpackage

// ===== design/ir_carrier_sweep_scheduler.sv =====
// ----------------------------------------------------------------------------
// ir_carrier_sweep_scheduler
// Burst scheduler with a triangle sweep of the IR carrier frequency.
//
// Input channel (in_valid/in_stall/in_data) takes tick, run/stop toggle,
// next mode and carrier reset items. Every accepted item yields exactly one
// result on the output channel (out_valid/out_stall/out_data).
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one item per cycle while the receiver does not stall; the state
// update is one pass of compare, add and clamp logic ahead of the result register.
// When the receiver stalls, the result register holds and in_stall rises
// only while a held result is still waiting; a result that leaves in the
// same cycle frees the slot for the next transfer.
// Reset (rst, synchronous) stops the scheduler, loads the accumulator with
// the interval reset value, sets narrow mode, carrier 36 kHz sweeping up,
// clears the burst count and restores both configuration registers.
// Configuration: cfg_write with cfg_index 0 sets the burst interval,
// index 1 the burst length; write only while idle.
// ----------------------------------------------------------------------------
module ir_carrier_sweep_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  isc_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output isc_pkg::out_item_t                 out_data,
  input  logic                               cfg_write,
  input  logic [isc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [isc_pkg::CfgDataWidth-1:0]   cfg_data
);

  isc_pkg::state_t    st;
  isc_pkg::state_t    st_next;
  isc_pkg::out_item_t result;
  logic [15:0]        burst_interval;
  logic [15:0]        burst_length;
  logic               accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  isc_step u_step (
    .cur      (st),
    .item     (in_data),
    .interval (burst_interval),
    .length   (burst_length),
    .nxt      (st_next),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_interval <= isc_pkg::INTERVAL_RESET;
      burst_length   <= isc_pkg::LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        isc_pkg::CFG_BURST_INTERVAL: burst_interval <= cfg_data;
        isc_pkg::CFG_BURST_LENGTH:   burst_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.running          <= 1'b0;
      st.elapsed_acc      <= {1'b0, isc_pkg::INTERVAL_RESET};
      st.sweep.carrier    <= isc_pkg::NARROW_MIN_HZ;
      st.sweep.going_up   <= 1'b1;
      st.mode             <= isc_pkg::MODE_NARROW;
      st.burst_counter    <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.func == isc_pkg::FUNC_TOGGLE |=>
      out_data.is_running != $past(st.running))
    else $error("toggle did not flip the run flag");

  a_fire_counts: assert property (@(posedge clk) disable iff (rst)
    accept && result.burst_fire |=>
      out_data.burst_total == $past(st.burst_counter) + 32'd1)
    else $error("burst count did not advance on a fired burst");

  a_no_fire_no_count: assert property (@(posedge clk) disable iff (rst)
    accept && !result.burst_fire |=> st.burst_counter == $past(st.burst_counter))
    else $error("burst count moved without a burst");

  a_carrier_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.current_carrier_hz >= isc_pkg::WIDE_MIN_HZ &&
                  out_data.current_carrier_hz <= isc_pkg::WIDE_MAX_HZ)
    else $error("carrier left the supported range");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result was lost or changed");

endmodule

// ===== design/isc_sweep.sv =====
// ----------------------------------------------------------------------------
// isc_sweep
// Carrier limits of a mode, one triangle sweep step and the carrier restart.
// ----------------------------------------------------------------------------
module isc_sweep (
  input  logic [1:0]      mode,
  input  isc_pkg::sweep_t cur,
  output isc_pkg::sweep_t advanced,
  output isc_pkg::sweep_t restart
);

  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] step;
  logic [16:0] up_sum;
  logic [16:0] lo_sum;

  always_comb begin
    unique case (mode)
      isc_pkg::MODE_WIDE: begin
        lo   = isc_pkg::WIDE_MIN_HZ;
        hi   = isc_pkg::WIDE_MAX_HZ;
        step = isc_pkg::WIDE_STEP_HZ;
      end
      isc_pkg::MODE_FIXED: begin
        lo   = isc_pkg::FIXED_HZ;
        hi   = isc_pkg::FIXED_HZ;
        step = isc_pkg::NARROW_STEP_HZ;
      end
      default: begin
        lo   = isc_pkg::NARROW_MIN_HZ;
        hi   = isc_pkg::NARROW_MAX_HZ;
        step = isc_pkg::NARROW_STEP_HZ;
      end
    endcase
  end

  assign up_sum = {1'b0, cur.carrier} + {1'b0, step};
  assign lo_sum = {1'b0, lo} + {1'b0, step};

  always_comb begin
    advanced = cur;
    if (mode != isc_pkg::MODE_FIXED) begin
      if (cur.going_up && up_sum >= {1'b0, hi}) begin
        advanced.carrier  = hi;
        advanced.going_up = 1'b0;
      end else if (!cur.going_up && {1'b0, cur.carrier} <= lo_sum) begin
        advanced.carrier  = lo;
        advanced.going_up = 1'b1;
      end else if (cur.going_up) begin
        advanced.carrier = up_sum[15:0];
      end else begin
        advanced.carrier = cur.carrier - step;
      end
    end
  end

  assign restart.carrier  = lo;
  assign restart.going_up = 1'b1;

endmodule

// ===== design/isc_step.sv =====
// ----------------------------------------------------------------------------
// isc_step
// Next state and result of one item: tick accumulation, run toggle, mode step, carrier reset.
// ----------------------------------------------------------------------------
module isc_step (
  input  isc_pkg::state_t    cur,
  input  isc_pkg::in_item_t  item,
  input  logic [15:0]        interval,
  input  logic [15:0]        length,
  output isc_pkg::state_t    nxt,
  output isc_pkg::out_item_t result
);

  logic [1:0]                   mode_next;
  logic [isc_pkg::AccWidth:0]   sum;
  logic [isc_pkg::AccWidth-1:0] acc_sat;
  isc_pkg::sweep_t              cur_adv;
  isc_pkg::sweep_t              cur_restart;
  isc_pkg::sweep_t              nxt_adv;
  isc_pkg::sweep_t              nxt_restart;
  logic                         fire;
  logic                         stop;

  isc_sweep u_sweep_cur (
    .mode     (cur.mode),
    .cur      (cur.sweep),
    .advanced (cur_adv),
    .restart  (cur_restart)
  );

  always_comb begin
    unique case (cur.mode)
      isc_pkg::MODE_NARROW: mode_next = isc_pkg::MODE_WIDE;
      isc_pkg::MODE_WIDE:   mode_next = isc_pkg::MODE_FIXED;
      default:              mode_next = isc_pkg::MODE_NARROW;
    endcase
  end

  isc_sweep u_sweep_next (
    .mode     (mode_next),
    .cur      (cur.sweep),
    .advanced (nxt_adv),
    .restart  (nxt_restart)
  );

  assign sum     = {1'b0, cur.elapsed_acc} + {{(isc_pkg::AccWidth + 1 - 16){1'b0}}, item.dt_ms};
  assign acc_sat = sum[isc_pkg::AccWidth] ? isc_pkg::ACC_MAX : sum[isc_pkg::AccWidth-1:0];

  always_comb begin
    nxt  = cur;
    fire = 1'b0;
    stop = 1'b0;
    unique case (item.func)
      isc_pkg::FUNC_TICK: begin
        if (cur.running) begin
          nxt.elapsed_acc = acc_sat;
          if (acc_sat >= {1'b0, interval}) begin
            nxt.elapsed_acc = '0;
            if (!item.emitter_ok) begin
              nxt.running = 1'b0;
              stop        = 1'b1;
            end else begin
              fire              = 1'b1;
              nxt.burst_counter = cur.burst_counter + 32'd1;
              nxt.sweep         = cur_adv;
            end
          end
        end
      end
      isc_pkg::FUNC_TOGGLE: begin
        nxt.running     = !cur.running;
        nxt.elapsed_acc = {1'b0, interval};
        stop            = cur.running;
      end
      isc_pkg::FUNC_NEXT_MODE: begin
        nxt.mode  = mode_next;
        nxt.sweep = nxt_restart;
      end
      default: begin
        nxt.sweep = cur_restart;
      end
    endcase
  end

  always_comb begin
    result.burst_fire         = fire;
    result.burst_carrier_hz   = fire ? cur.sweep.carrier : 16'd0;
    result.burst_ms           = fire ? length : 16'd0;
    result.stop_emitter       = stop;
    result.is_running         = nxt.running;
    result.sweep_mode         = nxt.mode;
    result.current_carrier_hz = nxt.sweep.carrier;
    result.burst_total        = nxt.burst_counter;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR carrier sweep scheduler. A short directed
// table covers stopped ticks, the narrow sweep turning at both limits, emitter
// failure, all modes and carrier resets. Random phases then run under several
// interval and length settings. Both channels idle at random, the output side
// holds off once for a long stretch, and every result is compared field by
// field with an in-bench schedule predictor, or with table values on typed rows.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    isc_pkg::in_item_t  stim;
    logic               typed;
    isc_pkg::out_item_t want;
  } dir_row_t;

  localparam int DirRows    = 25;
  localparam int NumPhases  = 5;
  localparam int HoldCycles = 60;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  isc_pkg::in_item_t                 in_data = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  isc_pkg::out_item_t                out_data;
  logic                              cfg_write = 1'b0;
  logic [isc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [isc_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  // predicted scheduler state and register copies
  logic                         sched_running;
  logic [isc_pkg::AccWidth-1:0] sched_acc;
  logic [15:0]                  sched_hz;
  logic                         sched_up;
  logic [1:0]                   sched_mode;
  logic [31:0]                  sched_bursts;
  logic [15:0]                  reg_interval;
  logic [15:0]                  reg_length;

  isc_pkg::out_item_t sched_q[$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  bursts_predicted = 0;
  int  stops_predicted = 0;
  int  settings_used = 1;
  int  push_through = 0;
  int  rx_wait = 0;
  bit  tx_fast = 1'b0;
  bit  rx_fast = 1'b0;
  bit  hold_req = 1'b0;
  bit  draining = 1'b0;

  int unsigned phase_interval[NumPhases] = '{1, 65535, 0, 120, 0};
  int unsigned phase_length[NumPhases]   = '{1, 65535, 777, 46, 0};
  int          phase_items[NumPhases]    = '{120, 100, 80, 150, 200};

  dir_row_t dir_rows[DirRows] = '{
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b1,
      '{1'b0, 16'd0, 16'd0, 1'b0, 1'b0, isc_pkg::MODE_NARROW,
        isc_pkg::NARROW_MIN_HZ, 32'd0}},
    '{'{isc_pkg::FUNC_TOGGLE, 16'd1234, 1'b0}, 1'b1,
      '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, isc_pkg::MODE_NARROW,
        isc_pkg::NARROW_MIN_HZ, 32'd0}},
    '{'{isc_pkg::FUNC_TICK, 16'd0, 1'b1}, 1'b1,
      '{1'b1, isc_pkg::NARROW_MIN_HZ, isc_pkg::LENGTH_RESET, 1'b0, 1'b1,
        isc_pkg::MODE_NARROW, 16'd37000, 32'd1}},
    '{'{isc_pkg::FUNC_TICK, 16'd119, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'd1, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_NEXT_MODE, 16'h5A5A, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TOGGLE, 16'hA5A5, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'd0, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'd120, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_RESET_HZ, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{isc_pkg::FUNC_NEXT_MODE, 16'd0, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_RESET_HZ, 16'd0, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_NEXT_MODE, 16'd7, 1'b0}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TOGGLE, 16'd0, 1'b1}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TOGGLE, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{isc_pkg::FUNC_TICK, 16'd0, 1'b1}, 1'b0, '0}
  };

  ir_carrier_sweep_scheduler uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic mode_bounds(output logic [15:0] lo, output logic [15:0] hi,
                             output logic [15:0] st);
    case (sched_mode)
      isc_pkg::MODE_WIDE: begin
        lo = isc_pkg::WIDE_MIN_HZ;
        hi = isc_pkg::WIDE_MAX_HZ;
        st = isc_pkg::WIDE_STEP_HZ;
      end
      isc_pkg::MODE_FIXED: begin
        lo = isc_pkg::FIXED_HZ;
        hi = isc_pkg::FIXED_HZ;
        st = isc_pkg::NARROW_STEP_HZ;
      end
      default: begin
        lo = isc_pkg::NARROW_MIN_HZ;
        hi = isc_pkg::NARROW_MAX_HZ;
        st = isc_pkg::NARROW_STEP_HZ;
      end
    endcase
  endtask

  task automatic restart_carrier;
    logic [15:0] lo, hi, st;
    mode_bounds(lo, hi, st);
    sched_hz = lo;
    sched_up = 1'b1;
  endtask

  task automatic predict_schedule(input isc_pkg::in_item_t item,
                                  output isc_pkg::out_item_t res);
    logic [isc_pkg::AccWidth:0] sum;
    logic [15:0]                lo, hi, st;
    res = '0;
    case (item.func)
      isc_pkg::FUNC_TICK: begin
        if (sched_running) begin
          sum = {1'b0, sched_acc} + {2'b00, item.dt_ms};
          sched_acc = (sum > {1'b0, isc_pkg::ACC_MAX}) ? isc_pkg::ACC_MAX :
                      sum[isc_pkg::AccWidth-1:0];
          if (sched_acc >= {1'b0, reg_interval}) begin
            sched_acc = '0;
            if (!item.emitter_ok) begin
              sched_running = 1'b0;
              res.stop_emitter = 1'b1;
            end else begin
              res.burst_fire = 1'b1;
              res.burst_carrier_hz = sched_hz;
              res.burst_ms = reg_length;
              sched_bursts = sched_bursts + 32'd1;
              mode_bounds(lo, hi, st);
              if (sched_mode != isc_pkg::MODE_FIXED) begin
                if (sched_up && ({1'b0, sched_hz} + {1'b0, st} >= {1'b0, hi})) begin
                  sched_hz = hi;
                  sched_up = 1'b0;
                end else if (!sched_up && ({1'b0, sched_hz} <= {1'b0, lo} + {1'b0, st})) begin
                  sched_hz = lo;
                  sched_up = 1'b1;
                end else if (sched_up) begin
                  sched_hz = sched_hz + st;
                end else begin
                  sched_hz = sched_hz - st;
                end
              end
            end
          end
        end
      end
      isc_pkg::FUNC_TOGGLE: begin
        sched_running = !sched_running;
        sched_acc = {1'b0, reg_interval};
        res.stop_emitter = !sched_running;
      end
      isc_pkg::FUNC_NEXT_MODE: begin
        case (sched_mode)
          isc_pkg::MODE_NARROW: sched_mode = isc_pkg::MODE_WIDE;
          isc_pkg::MODE_WIDE:   sched_mode = isc_pkg::MODE_FIXED;
          default:              sched_mode = isc_pkg::MODE_NARROW;
        endcase
        restart_carrier();
      end
      default: restart_carrier();
    endcase
    res.is_running = sched_running;
    res.sweep_mode = sched_mode;
    res.current_carrier_hz = sched_hz;
    res.burst_total = sched_bursts;
  endtask

  task automatic send_item(input isc_pkg::in_item_t item, input logic typed,
                           input isc_pkg::out_item_t want);
    int                 gap;
    isc_pkg::out_item_t res;
    if ($urandom_range(0, 29) == 0) tx_fast = !tx_fast;
    if (push_through > 0) begin
      gap = 0;
      push_through--;
    end else begin
      gap = tx_fast ? 0 : int'($urandom_range(0, 9));
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    predict_schedule(item, res);
    sched_q.push_back(typed ? want : res);
    if (res.burst_fire) bursts_predicted++;
    if (res.stop_emitter) stops_predicted++;
  endtask

  task automatic wait_idle;
    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input isc_pkg::out_item_t got);
    isc_pkg::out_item_t want;
    if (sched_q.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = sched_q.pop_front();
      results_checked++;
      cmp_field("burst_fire", 32'(want.burst_fire), 32'(got.burst_fire));
      cmp_field("burst_carrier_hz", 32'(want.burst_carrier_hz),
                32'(got.burst_carrier_hz));
      cmp_field("burst_ms", 32'(want.burst_ms), 32'(got.burst_ms));
      cmp_field("stop_emitter", 32'(want.stop_emitter), 32'(got.stop_emitter));
      cmp_field("is_running", 32'(want.is_running), 32'(got.is_running));
      cmp_field("sweep_mode", 32'(want.sweep_mode), 32'(got.sweep_mode));
      cmp_field("current_carrier_hz", 32'(want.current_carrier_hz),
                32'(got.current_carrier_hz));
      cmp_field("burst_total", want.burst_total, got.burst_total);
    end
  endtask

  // output side: after each transfer, stall for a random wait, a long hold once on request, or not while draining
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
        if (draining) begin
          rx_wait = 0;
        end else if (hold_req) begin
          rx_wait = HoldCycles;
          hold_req = 1'b0;
        end else begin
          rx_wait = rx_fast ? 0 : int'($urandom_range(0, 9));
        end
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  initial begin
    isc_pkg::in_item_t item;
    int                roll;
    int                sent;
    int                span;
    reg_interval = isc_pkg::INTERVAL_RESET;
    reg_length = isc_pkg::LENGTH_RESET;
    sched_running = 1'b0;
    sched_acc = {1'b0, isc_pkg::INTERVAL_RESET};
    sched_mode = isc_pkg::MODE_NARROW;
    sched_bursts = '0;
    restart_carrier();
    phase_interval[4] = $urandom_range(2, 3000);
    phase_length[4] = $urandom_range(1, 65535);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++) begin
      send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      cfg_write <= 1'b1;
      cfg_index <= isc_pkg::CFG_BURST_INTERVAL;
      cfg_data <= phase_interval[p][15:0];
      @(posedge clk);
      cfg_index <= isc_pkg::CFG_BURST_LENGTH;
      cfg_data <= phase_length[p][15:0];
      @(posedge clk);
      cfg_write <= 1'b0;
      reg_interval = phase_interval[p][15:0];
      reg_length = phase_length[p][15:0];
      settings_used++;
      span = int'(phase_interval[p] / 3 + 1);
      sent = 0;
      while (sent < phase_items[p]) begin
        roll = int'($urandom_range(0, 99));
        if (sched_running) begin
          item.func = (roll < 78) ? isc_pkg::FUNC_TICK :
                      (roll < 84) ? isc_pkg::FUNC_TOGGLE :
                      (roll < 94) ? isc_pkg::FUNC_NEXT_MODE : isc_pkg::FUNC_RESET_HZ;
        end else begin
          item.func = (roll < 45) ? isc_pkg::FUNC_TOGGLE :
                      (roll < 75) ? isc_pkg::FUNC_TICK :
                      (roll < 88) ? isc_pkg::FUNC_NEXT_MODE : isc_pkg::FUNC_RESET_HZ;
        end
        roll = int'($urandom_range(0, 99));
        if (roll < 5) begin
          item.dt_ms = 16'd0;
        end else if (roll < 10) begin
          item.dt_ms = 16'hFFFF;
        end else if (roll < 25) begin
          item.dt_ms = 16'($urandom);
        end else begin
          item.dt_ms = 16'($urandom_range(0, span));
        end
        item.emitter_ok = ($urandom_range(0, 99) >= 7);
        if (!(item.func == isc_pkg::FUNC_TICK && !sched_running)) sent++;
        // hold the output side while the input keeps offering
        if (p == 3 && sent == 30 && push_through == 0) begin
          hold_req = 1'b1;
          push_through = 20;
        end
        // drain everything before going on
        if (p == 4 && sent == 100) wait_idle();
        send_item(item, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    draining = 1'b1;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Checked %0d results over %0d register settings, all four item kinds.",
             results_checked, settings_used);
    $display("Predicted %0d bursts and %0d emitter stops; long output hold and drain pause run.",
             bursts_predicted, stops_predicted);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sched_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
